// ===== hw/rtl/hcb_pkg.sv =====
// Shared types, constants and helpers for the Huffman code builder.
package hcb_pkg;

    localparam int SYMBOL_BITS  = 8;
    localparam int COUNT_BITS   = 16;
    localparam int MAX_CODE_LEN = 24;

    localparam int NSYM    = 1 << SYMBOL_BITS;
    localparam int NODE_W  = SYMBOL_BITS + 1;
    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 2);
    localparam int QENT_W  = NODE_W + COUNT_BITS;
    localparam int CODE_E_W = MAX_CODE_LEN + LEN_W;

    localparam logic [2:0] OP_COUNT  = 3'd0;
    localparam logic [2:0] OP_BUILD  = 3'd1;
    localparam logic [2:0] OP_ENCODE = 3'd2;
    localparam logic [2:0] OP_DECODE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ABSENT   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] symbol;
        logic       coded_bit;
    } req_t;

    typedef struct packed {
        logic [7:0]  decoded_symbol;
        logic [23:0] code_word;
        logic [4:0]  code_length;
        logic [8:0]  distinct_symbols;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [NODE_W-1:0]     node;
        logic [COUNT_BITS-1:0] weight;
    } qent_t;

    typedef struct packed {
        qent_t                  e;
        logic [SYMBOL_BITS-1:0] pos;
    } cand_t;

    function automatic logic key_less(input qent_t a, input qent_t b);
        key_less = (a.weight < b.weight) || ((a.weight == b.weight) && (a.node < b.node));
    endfunction

endpackage

// ===== hw/rtl/huffman_code_builder_codec.sv =====
// Top level: histogram, Huffman tree build, encode and bit-serial decode.
//
//  channel | dir | payload | handshake
//  req     | in  | req_t   | req_valid / req_ready
//  rsp     | out | rsp_t   | rsp_valid / rsp_ready
//
// Count, encode, decode to a leaf: accept and read, check/write, result to output
// register. Decode to an internal node: accept and read, then check. Clear: done on acceptance.
// Build: histogram scan that also empties the code table, then per merge a scan of
// the live entries and the writes, then a walk over the internal nodes.
// Reset clears the histogram through valid bits; no clearing pass.
// A finished result waits in the output register; the next word is taken meanwhile.
module huffman_code_builder_codec
    import hcb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CNT_CHK    = 4'd1;
    localparam logic [3:0] S_ENC_CHK    = 4'd2;
    localparam logic [3:0] S_DEC_CHK    = 4'd3;
    localparam logic [3:0] S_BLD_SCAN   = 4'd4;
    localparam logic [3:0] S_BLD_DECIDE = 4'd5;
    localparam logic [3:0] S_MRG_SCAN   = 4'd6;
    localparam logic [3:0] S_MRG_WR1    = 4'd7;
    localparam logic [3:0] S_MRG_WR2    = 4'd8;
    localparam logic [3:0] S_WALK_RD    = 4'd9;
    localparam logic [3:0] S_WALK_HOLD  = 4'd10;
    localparam logic [3:0] S_WALK_LEFT  = 4'd11;
    localparam logic [3:0] S_WALK_RIGHT = 4'd12;
    localparam logic [3:0] S_OUT        = 4'd13;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;
    localparam int SB = SYMBOL_BITS;

    logic [3:0] state_reg, state_next;
    logic [SB-1:0] sym_reg, sym_next;
    logic bit_reg, bit_next;
    logic [SB:0] scan_reg, scan_next;
    logic pend_reg, pend_next;
    logic [SB-1:0] pend_pos_reg, pend_pos_next;
    logic [SB:0] n_reg, n_next;
    logic [SB-1:0] last_sym_reg, last_sym_next;
    logic [SB:0] live_reg, live_next;
    logic [NODE_W-1:0] next_reg, next_next;
    cand_t b1_reg, b1_next, b2_reg, b2_next;
    logic b1v_reg, b1v_next, b2v_reg, b2v_next;
    qent_t last_ent_reg, last_ent_next;
    logic [SB-1:0] k_reg, k_next;
    logic [2*NODE_W-1:0] hold_ch_reg, hold_ch_next;
    logic [MAX_CODE_LEN-1:0] pbits_reg, pbits_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [NODE_W-1:0] root_reg, root_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic built_reg, built_next;
    logic [SB:0] leaf_reg, leaf_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [NSYM-1:0] cnt_vld_reg, cnt_vld_next;
    rsp_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg, out_next;

    logic cnt_we, cnt_re;
    logic [SB-1:0] cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic q_we, q_re;
    logic [SB-1:0] q_waddr, q_raddr;
    qent_t q_wdata, q_rdata;
    logic ch_we, ch_re;
    logic [SB-1:0] ch_waddr, ch_raddr;
    logic [2*NODE_W-1:0] ch_wdata, ch_rdata;
    logic wk_we, wk_re;
    logic [SB-1:0] wk_waddr, wk_raddr;
    logic [CODE_E_W-1:0] wk_wdata, wk_rdata;
    logic cd_we, cd_re;
    logic [SB-1:0] cd_waddr, cd_raddr;
    logic [CODE_E_W-1:0] cd_wdata, cd_rdata;

    logic [COUNT_BITS-1:0] cnt_val;
    qent_t scan_x;
    logic [SB:0] live_m1;
    logic [SB-1:0] last_pos;
    qent_t new_e;
    logic [NODE_W-1:0] child;
    logic [LEN_W-1:0] len_c;
    logic [MAX_CODE_LEN-1:0] bits_c;
    logic place_bit;
    logic [NODE_W-1:0] dec_child;

    hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(NSYM)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    hcb_ram #(.WIDTH(QENT_W), .DEPTH(NSYM)) u_q_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
    );

    hcb_ram #(.WIDTH(2*NODE_W), .DEPTH(NSYM)) u_ch_ram (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .re(ch_re), .raddr(ch_raddr), .rdata(ch_rdata)
    );

    hcb_ram #(.WIDTH(CODE_E_W), .DEPTH(NSYM)) u_walk_ram (
        .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
        .re(wk_re), .raddr(wk_raddr), .rdata(wk_rdata)
    );

    hcb_ram #(.WIDTH(CODE_E_W), .DEPTH(NSYM)) u_code_ram (
        .clk(clk), .we(cd_we), .waddr(cd_waddr), .wdata(cd_wdata),
        .re(cd_re), .raddr(cd_raddr), .rdata(cd_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign live_m1  = live_reg - 1'b1;
    assign last_pos = live_m1[SB-1:0];
    assign scan_x   = q_rdata;
    assign new_e    = '{node: next_reg, weight: b1_reg.e.weight + b2_reg.e.weight};
    assign dec_child = bit_reg ? ch_rdata[NODE_W-1:0] : ch_rdata[2*NODE_W-1:NODE_W];

    always_comb
    begin
        place_bit = (state_reg == S_WALK_RIGHT);
        child = place_bit ? hold_ch_reg[NODE_W-1:0] : hold_ch_reg[2*NODE_W-1:NODE_W];
        if (plen_reg >= LEN_W'(MAX_CODE_LEN))
        begin
            len_c = LEN_W'(MAX_CODE_LEN + 1);
        end
        else
        begin
            len_c = plen_reg + 1'b1;
        end
        if (len_c <= LEN_W'(MAX_CODE_LEN))
        begin
            bits_c = {pbits_reg[MAX_CODE_LEN-2:0], place_bit};
        end
        else
        begin
            bits_c = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        bit_next       = bit_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        n_next         = n_reg;
        last_sym_next  = last_sym_reg;
        live_next      = live_reg;
        next_next      = next_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        b1v_next       = b1v_reg;
        b2v_next       = b2v_reg;
        last_ent_next  = last_ent_reg;
        k_next         = k_reg;
        hold_ch_next   = hold_ch_reg;
        pbits_next     = pbits_reg;
        plen_next      = plen_reg;
        root_next      = root_reg;
        cursor_next    = cursor_reg;
        built_next     = built_reg;
        leaf_next      = leaf_reg;
        total_next     = total_reg;
        cnt_vld_next   = cnt_vld_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        cnt_we = 1'b0; cnt_waddr = sym_reg; cnt_wdata = '0;
        cnt_re = 1'b0; cnt_raddr = req.symbol[SB-1:0];
        q_we = 1'b0; q_waddr = '0; q_wdata = '0;
        q_re = 1'b0; q_raddr = scan_reg[SB-1:0];
        ch_we = 1'b0; ch_waddr = next_reg[SB-1:0];
        ch_wdata = {b1_reg.e.node, b2_reg.e.node};
        ch_re = 1'b0; ch_raddr = k_reg;
        wk_we = 1'b0; wk_waddr = child[SB-1:0]; wk_wdata = {bits_c, len_c};
        wk_re = 1'b0; wk_raddr = k_reg;
        cd_we = 1'b0; cd_waddr = child[SB-1:0]; cd_wdata = {bits_c, len_c};
        cd_re = 1'b0; cd_raddr = req.symbol[SB-1:0];

        cnt_val = cnt_vld_reg[pend_pos_reg] ? cnt_rdata : '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    sym_next = req.symbol[SB-1:0];
                    bit_next = req.coded_bit;
                    res_next = '0;
                    case (req.operation)
                        OP_COUNT:
                        begin
                            cnt_re = 1'b1;
                            state_next = S_CNT_CHK;
                        end
                        OP_BUILD:
                        begin
                            scan_next = '0;
                            pend_next = 1'b0;
                            n_next = '0;
                            state_next = S_BLD_SCAN;
                        end
                        OP_ENCODE:
                        begin
                            cd_re = 1'b1;
                            state_next = S_ENC_CHK;
                        end
                        OP_DECODE:
                        begin
                            if (!built_reg)
                            begin
                                res_next.status = ST_ABSENT;
                                state_next = S_OUT;
                            end
                            else if (!root_reg[NODE_W-1])
                            begin
                                res_next.decoded_symbol = 8'(root_reg[SB-1:0]);
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ch_re = 1'b1;
                                ch_raddr = cursor_reg[SB-1:0];
                                state_next = S_DEC_CHK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_vld_next = '0;
                            total_next = '0;
                            built_next = 1'b0;
                            leaf_next = '0;
                            cursor_next = '0;
                            root_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CNT_CHK:
            begin
                cnt_val = cnt_vld_reg[sym_reg] ? cnt_rdata : '0;
                if (cnt_val == COUNT_LIMIT || total_reg == COUNT_LIMIT)
                begin
                    res_next.status = ST_OVERFLOW;
                end
                else
                begin
                    cnt_we = 1'b1;
                    cnt_wdata = cnt_val + 1'b1;
                    cnt_vld_next[sym_reg] = 1'b1;
                    total_next = total_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_ENC_CHK:
            begin
                if (!built_reg || cd_rdata[LEN_W-1:0] == '0)
                begin
                    res_next.status = ST_ABSENT;
                end
                else
                begin
                    res_next.code_word = 24'(cd_rdata[CODE_E_W-1:LEN_W]);
                    res_next.code_length = 5'(cd_rdata[LEN_W-1:0]);
                end
                state_next = S_OUT;
            end
            S_DEC_CHK:
            begin
                if (!dec_child[NODE_W-1])
                begin
                    cursor_next = root_reg;
                    res_next.decoded_symbol = 8'(dec_child[SB-1:0]);
                    state_next = S_OUT;
                end
                else
                begin
                    cursor_next = dec_child;
                    state_next = S_IDLE;
                end
            end
            S_BLD_SCAN:
            begin
                if (pend_reg && cnt_val != '0)
                begin
                    q_we = 1'b1;
                    q_waddr = n_reg[SB-1:0];
                    q_wdata = '{node: NODE_W'(pend_pos_reg), weight: cnt_val};
                    n_next = n_reg + 1'b1;
                    last_sym_next = pend_pos_reg;
                end
                if (!scan_reg[SB])
                begin
                    cnt_re = 1'b1;
                    cnt_raddr = scan_reg[SB-1:0];
                    cd_we = 1'b1;
                    cd_waddr = scan_reg[SB-1:0];
                    cd_wdata = '0;
                    pend_next = 1'b1;
                    pend_pos_next = scan_reg[SB-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_BLD_DECIDE;
                    end
                end
            end
            S_BLD_DECIDE:
            begin
                if (n_reg == '0)
                begin
                    built_next = 1'b0;
                    leaf_next = '0;
                    cursor_next = '0;
                    res_next.status = ST_EMPTY;
                    state_next = S_OUT;
                end
                else if (n_reg == (SB+1)'(1))
                begin
                    root_next = {1'b0, last_sym_reg};
                    cd_we = 1'b1;
                    cd_waddr = last_sym_reg;
                    cd_wdata = {MAX_CODE_LEN'(1), LEN_W'(1)};
                    built_next = 1'b1;
                    leaf_next = n_reg;
                    cursor_next = {1'b0, last_sym_reg};
                    state_next = S_OUT;
                end
                else
                begin
                    live_next = n_reg;
                    next_next = NODE_W'(NSYM);
                    scan_next = '0;
                    pend_next = 1'b0;
                    b1v_next = 1'b0;
                    b2v_next = 1'b0;
                    state_next = S_MRG_SCAN;
                end
            end
            S_MRG_SCAN:
            begin
                if (pend_reg)
                begin
                    if (!b1v_reg || key_less(scan_x, b1_reg.e))
                    begin
                        b2_next = b1_reg;
                        b2v_next = b1v_reg;
                        b1_next = '{e: scan_x, pos: pend_pos_reg};
                        b1v_next = 1'b1;
                    end
                    else if (!b2v_reg || key_less(scan_x, b2_reg.e))
                    begin
                        b2_next = '{e: scan_x, pos: pend_pos_reg};
                        b2v_next = 1'b1;
                    end
                    if (pend_pos_reg == last_pos)
                    begin
                        last_ent_next = scan_x;
                    end
                end
                if (scan_reg < live_reg)
                begin
                    q_re = 1'b1;
                    pend_next = 1'b1;
                    pend_pos_next = scan_reg[SB-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_MRG_WR1;
                    end
                end
            end
            S_MRG_WR1, S_MRG_WR2:
            begin
                if (state_reg == S_MRG_WR1)
                begin
                    ch_we = 1'b1;
                    q_we = 1'b1;
                    q_wdata = new_e;
                    q_waddr = (b1_reg.pos == last_pos) ? b2_reg.pos : b1_reg.pos;
                end
                else
                begin
                    q_we = 1'b1;
                    q_wdata = last_ent_reg;
                    q_waddr = b2_reg.pos;
                end
                if (state_reg == S_MRG_WR1 && b1_reg.pos != last_pos && b2_reg.pos != last_pos)
                begin
                    state_next = S_MRG_WR2;
                end
                else
                begin
                    live_next = live_m1;
                    next_next = next_reg + 1'b1;
                    scan_next = '0;
                    pend_next = 1'b0;
                    b1v_next = 1'b0;
                    b2v_next = 1'b0;
                    if (live_reg == (SB+1)'(2))
                    begin
                        root_next = next_reg;
                        k_next = next_reg[SB-1:0];
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        state_next = S_MRG_SCAN;
                    end
                end
            end
            S_WALK_RD:
            begin
                ch_re = 1'b1;
                wk_re = 1'b1;
                state_next = S_WALK_HOLD;
            end
            S_WALK_HOLD:
            begin
                hold_ch_next = ch_rdata;
                if (k_reg == root_reg[SB-1:0])
                begin
                    pbits_next = '0;
                    plen_next = '0;
                end
                else
                begin
                    pbits_next = wk_rdata[CODE_E_W-1:LEN_W];
                    plen_next = wk_rdata[LEN_W-1:0];
                end
                state_next = S_WALK_LEFT;
            end
            S_WALK_LEFT, S_WALK_RIGHT:
            begin
                if (!child[NODE_W-1])
                begin
                    if (len_c <= LEN_W'(MAX_CODE_LEN))
                    begin
                        cd_we = 1'b1;
                    end
                end
                else
                begin
                    wk_we = 1'b1;
                end
                if (state_reg == S_WALK_LEFT)
                begin
                    state_next = S_WALK_RIGHT;
                end
                else if (k_reg == '0)
                begin
                    built_next = 1'b1;
                    leaf_next = n_reg;
                    cursor_next = root_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next = res_reg;
                    out_next.distinct_symbols = 9'(leaf_reg);
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            b1v_reg       <= 1'b0;
            b2v_reg       <= 1'b0;
            root_reg      <= '0;
            cursor_reg    <= '0;
            built_reg     <= 1'b0;
            leaf_reg      <= '0;
            total_reg     <= '0;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            b1v_reg       <= b1v_next;
            b2v_reg       <= b2v_next;
            root_reg      <= root_next;
            cursor_reg    <= cursor_next;
            built_reg     <= built_next;
            leaf_reg      <= leaf_next;
            total_reg     <= total_next;
            cnt_vld_reg   <= cnt_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        bit_reg      <= bit_next;
        scan_reg     <= scan_next;
        pend_pos_reg <= pend_pos_next;
        n_reg        <= n_next;
        last_sym_reg <= last_sym_next;
        live_reg     <= live_next;
        next_reg     <= next_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        last_ent_reg <= last_ent_next;
        k_reg        <= k_next;
        hold_ch_reg  <= hold_ch_next;
        pbits_reg    <= pbits_next;
        plen_reg     <= plen_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    a_cursor_internal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && built_reg && root_reg[NODE_W-1]) |-> cursor_reg[NODE_W-1])
        else $error("decode cursor left the internal nodes");

    a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MRG_WR1) |-> (b1v_reg && b2v_reg && b1_reg.pos != b2_reg.pos))
        else $error("merge without two distinct nodes");

    a_code_needs_tree: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.code_length != '0) |-> (rsp.status == ST_OK))
        else $error("code word with a bad status");

endmodule

// ===== hw/rtl/hcb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/sv/huffman_code_builder_codec_tb.sv =====
// Self-checking testbench for huffman_code_builder_codec with a built-in Huffman predictor.
`timescale 1ns / 100ps

module huffman_code_builder_codec_tb
    import hcb_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    rsp_t expected_rsp[$];
    int   errors = 0;
    int   cycles = 0;
    int   hold_cycles = 0;
    int   stall_left = 0;
    bit   rx_random = 1'b1;
    bit   tx_random = 1'b1;

    // predictor state
    int unsigned hist[NSYM];
    int unsigned hist_total;
    longint      wt[2*NSYM];
    int          kid_l[NSYM];
    int          kid_r[NSYM];
    int          pool[NSYM];
    longint      code_bits[NSYM];
    int          code_len[NSYM];
    longint      path_bits[NSYM];
    int          path_len[NSYM];
    int          cursor;
    bit          built;
    int          root;
    int          leaves;

    huffman_code_builder_codec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("huffman_code_builder_codec_tb: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_cycles--;
        end
        else if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (rx_random && $urandom_range(0, 7) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, rsp);
                errors++;
            end
            else
            begin
                if (rsp.decoded_symbol !== expected_rsp[0].decoded_symbol ||
                    rsp.code_word !== expected_rsp[0].code_word ||
                    rsp.code_length !== expected_rsp[0].code_length ||
                    rsp.distinct_symbols !== expected_rsp[0].distinct_symbols ||
                    rsp.status !== expected_rsp[0].status)
                begin
                    $display("%0t: mismatch expected %p actual %p",
                             $time, expected_rsp[0], rsp);
                    errors++;
                end
                void'(expected_rsp.pop_front());
            end
        end
    end

    function automatic int take_lightest(ref int live);
        int best;
        int node;
        best = 0;
        for (int i = 1; i < live; i++)
            if (wt[pool[i]] < wt[pool[best]] ||
                (wt[pool[i]] == wt[pool[best]] && pool[i] < pool[best]))
                best = i;
        node = pool[best];
        live--;
        pool[best] = pool[live];
        return node;
    endfunction

    function automatic void place_child(int child, longint pbits, int plen, int b);
        int     len;
        longint bits;
        len = plen + 1;
        bits = 0;
        if (len > MAX_CODE_LEN + 1)
            len = MAX_CODE_LEN + 1;
        if (len <= MAX_CODE_LEN)
            bits = (pbits << 1) | b;
        if (child < NSYM)
        begin
            if (len <= MAX_CODE_LEN)
            begin
                code_bits[child] = bits;
                code_len[child] = len;
            end
        end
        else
        begin
            path_bits[child - NSYM] = bits;
            path_len[child - NSYM] = len;
        end
    endfunction

    function automatic logic [1:0] build_codes();
        int n;
        int live;
        int next_node;
        int a;
        int b;
        n = 0;
        next_node = NSYM;
        for (int s = 0; s < NSYM; s++)
        begin
            code_bits[s] = 0;
            code_len[s] = 0;
            if (hist[s] != 0)
            begin
                wt[s] = hist[s];
                pool[n++] = s;
            end
        end
        if (n == 0)
        begin
            built = 1'b0;
            leaves = 0;
            cursor = 0;
            return ST_EMPTY;
        end
        if (n == 1)
        begin
            root = pool[0];
            code_bits[root] = 1;
            code_len[root] = 1;
        end
        else
        begin
            live = n;
            while (live > 1)
            begin
                a = take_lightest(live);
                b = take_lightest(live);
                wt[next_node] = wt[a] + wt[b];
                kid_l[next_node - NSYM] = a;
                kid_r[next_node - NSYM] = b;
                pool[live++] = next_node;
                next_node++;
            end
            root = next_node - 1;
            path_bits[root - NSYM] = 0;
            path_len[root - NSYM] = 0;
            for (int k = root - NSYM; k >= 0; k--)
            begin
                place_child(kid_l[k], path_bits[k], path_len[k], 0);
                place_child(kid_r[k], path_bits[k], path_len[k], 1);
            end
        end
        built = 1'b1;
        leaves = n;
        cursor = root;
        return ST_OK;
    endfunction

    function automatic void clear_model();
        for (int s = 0; s < NSYM; s++)
        begin
            hist[s] = 0;
            code_bits[s] = 0;
            code_len[s] = 0;
        end
        hist_total = 0;
        built = 1'b0;
        leaves = 0;
        cursor = 0;
        root = 0;
    endfunction

    function automatic void predict_word(req_t r);
        rsp_t e;
        int   child;
        int   sym;
        e = '0;
        sym = r.symbol;
        case (r.operation)
            OP_COUNT:
            begin
                if (hist[sym] >= 65535 || hist_total >= 65535)
                    e.status = ST_OVERFLOW;
                else
                begin
                    hist[sym]++;
                    hist_total++;
                    e.status = ST_OK;
                end
            end
            OP_BUILD:
                e.status = build_codes();
            OP_ENCODE:
            begin
                if (!built || code_len[sym] == 0)
                    e.status = ST_ABSENT;
                else
                begin
                    e.code_word = 24'(code_bits[sym]);
                    e.code_length = 5'(code_len[sym]);
                    e.status = ST_OK;
                end
            end
            OP_DECODE:
            begin
                if (!built)
                    e.status = ST_ABSENT;
                else if (root < NSYM)
                    e.decoded_symbol = 8'(root);
                else
                begin
                    if (cursor < NSYM)
                        cursor = root;
                    child = r.coded_bit ? kid_r[cursor - NSYM] : kid_l[cursor - NSYM];
                    if (child < NSYM)
                    begin
                        cursor = root;
                        e.decoded_symbol = 8'(child);
                    end
                    else
                    begin
                        cursor = child;
                        return;
                    end
                end
            end
            OP_CLEAR:
            begin
                clear_model();
                return;
            end
            default:
                return;
        endcase
        e.distinct_symbols = 9'(leaves);
        expected_rsp.push_back(e);
    endfunction

    task automatic send_word(logic [2:0] op, logic [7:0] sym, logic b);
        req_t r;
        int   gap;
        r.operation = op;
        r.symbol = sym;
        r.coded_bit = b;
        predict_word(r);
        gap = tx_random ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic idle_input();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic decode_code(int sym);
        for (int i = code_len[sym] - 1; i >= 0; i--)
            send_word(OP_DECODE, 8'($urandom), code_bits[sym][i]);
    endtask

    task automatic test_directed();
        send_word(OP_ENCODE, 8'd3, 1'b0);
        send_word(OP_DECODE, 8'd0, 1'b1);
        send_word(OP_BUILD, 8'd0, 1'b0);
        send_word(OP_COUNT, 8'd0, 1'b0);
        send_word(OP_COUNT, 8'd255, 1'b1);
        send_word(OP_COUNT, 8'd255, 1'b0);
        send_word(OP_BUILD, 8'hff, 1'b1);
        send_word(OP_ENCODE, 8'd0, 1'b0);
        send_word(OP_ENCODE, 8'd255, 1'b0);
        send_word(OP_ENCODE, 8'd7, 1'b0);
        send_word(OP_DECODE, 8'd0, 1'b0);
        send_word(OP_DECODE, 8'd0, 1'b1);
        send_word(3'd5, 8'hff, 1'b1);
        send_word(3'd6, 8'h00, 1'b0);
        send_word(3'd7, 8'haa, 1'b1);
        send_word(OP_CLEAR, 8'd0, 1'b0);
        send_word(OP_BUILD, 8'd0, 1'b0);
        send_word(OP_COUNT, 8'haa, 1'b0);
        send_word(OP_BUILD, 8'd0, 1'b0);
        send_word(OP_DECODE, 8'd0, 1'b0);
        send_word(OP_DECODE, 8'd0, 1'b1);
        send_word(OP_ENCODE, 8'haa, 1'b0);
        send_word(OP_ENCODE, 8'h55, 1'b0);
        send_word(OP_CLEAR, 8'd0, 1'b0);
    endtask

    task automatic test_full_alphabet();
        for (int s = 0; s < NSYM; s++)
            send_word(OP_COUNT, 8'(s), 1'b0);
        send_word(OP_COUNT, 8'd17, 1'b0);
        send_word(OP_BUILD, 8'd0, 1'b0);
        send_word(OP_ENCODE, 8'd17, 1'b0);
        send_word(OP_ENCODE, 8'd200, 1'b0);
        decode_code(200);
        send_word(OP_CLEAR, 8'd0, 1'b0);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        tx_random = 1'b0;
        for (int i = 0; i < 30; i++)
            send_word(OP_COUNT, 8'($urandom), 1'b0);
        tx_random = 1'b1;
        send_word(OP_CLEAR, 8'd0, 1'b0);
    endtask

    task automatic test_random_sets();
        int     issued;
        int     k;
        int     n;
        logic [7:0] alpha[];
        issued = 0;
        while (issued < 800)
        begin
            if ($urandom_range(0, 14) == 0)
                k = $urandom_range(13, 64);
            else
                k = $urandom_range(1, 12);
            alpha = new[k];
            foreach (alpha[i])
                alpha[i] = 8'($urandom);
            tx_random = ($urandom_range(0, 3) != 0);
            rx_random = ($urandom_range(0, 3) != 0);
            send_word(OP_CLEAR, 8'd0, 1'b0);
            n = $urandom_range(k, 3 * k + 10);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(3'($urandom_range(2, 7)), 8'($urandom), 1'($urandom));
                else
                    send_word(OP_COUNT,
                              alpha[$urandom_range(0, $urandom_range(0, k - 1))], 1'b0);
            end
            send_word(OP_BUILD, 8'($urandom), 1'($urandom));
            for (int i = 0; i < 20; i++)
            begin
                case ($urandom_range(0, 5))
                    0: send_word(OP_ENCODE, 8'($urandom), 1'b0);
                    1, 2: send_word(OP_ENCODE, alpha[$urandom_range(0, k - 1)], 1'b0);
                    3: send_word(OP_DECODE, 8'($urandom), 1'($urandom));
                    4: decode_code(alpha[$urandom_range(0, k - 1)]);
                    default: send_word(OP_COUNT, alpha[$urandom_range(0, k - 1)], 1'b1);
                endcase
            end
            issued += n + 22;
            if ($urandom_range(0, 4) == 0)
                send_word(OP_BUILD, 8'd0, 1'b0);
        end
        tx_random = 1'b1;
        rx_random = 1'b1;
    endtask

    initial
    begin
        int wait_cycles;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_full_alphabet();
        test_random_sets();
        idle_input();
        wait_cycles = 0;
        while (expected_rsp.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("huffman_code_builder_codec_tb: clean");
        else
            $display("huffman_code_builder_codec_tb: errors");
        $finish;
    end

endmodule
